// ===== rtl/qosm_pkg.sv =====
// Queue occupancy statistics monitor: shared types and constants.
// No dependencies; used by the output and configuration interfaces, the top level and the testbench.

package qosm_pkg;

  // event kinds on the input channel
  localparam logic [1:0] REQ_ARRIVAL   = 2'd0;
  localparam logic [1:0] REQ_DEPARTURE = 2'd1;
  localparam logic [1:0] REQ_OBSERVE   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FINITE_MODE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY = 8'd1;

  // fixed field widths
  localparam int CAP_W   = 16;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 48;
  localparam int MEAN_W  = 32;
  localparam int RATIO_W = 17;
  localparam int FRAC_W  = 16;

  localparam logic [CAP_W-1:0]   CAP_RESET = 16'd10;
  localparam logic [RATIO_W-1:0] ONE_Q16   = 17'h10000;

  // which quotient the shared divider is working on
  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_IDLE = 2'd1,
    DIV_LOSS = 2'd2
  } div_sel_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ELAP = 7'b0000010,
    S_UPD  = 7'b0000100,
    S_LOAD = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

endpackage

// ===== rtl/qosm_in_if.sv =====
// Input event channel: valid/ready with event kind, timestamp and drop mark.
// No dependencies.

interface qosm_in_if #(
  parameter int TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [TIME_BITS-1:0] event_time;
  logic                 was_dropped;

  modport source (output valid, req_type, event_time, was_dropped, input ready);
  modport sink   (input valid, req_type, event_time, was_dropped, output ready);
endinterface

// ===== rtl/qosm_out_if.sv =====
// Result channel: valid/ready with the statistics of one observe event.
// Depends on qosm_pkg.

interface qosm_out_if
  import qosm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [MEAN_W-1:0]  mean_occupancy;
  logic [RATIO_W-1:0] idle_fraction;
  logic [RATIO_W-1:0] loss_ratio;
  logic               loss_valid;
  logic [CNT_W-1:0]   observe_count;
  logic               underflow_seen;
  logic               overflow_seen;

  modport source (output valid, mean_occupancy, idle_fraction, loss_ratio, loss_valid,
                  observe_count, underflow_seen, overflow_seen, input ready);
  modport sink   (input valid, mean_occupancy, idle_fraction, loss_ratio, loss_valid,
                  observe_count, underflow_seen, overflow_seen, output ready);
endinterface

// ===== rtl/qosm_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
// Depends on qosm_pkg.

interface qosm_cfg_if
  import qosm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/queue_occupancy_statistics_monitor_unit.sv =====
// Queue occupancy statistics monitor, top level.
// Depends on qosm_pkg, qosm_in_if, qosm_out_if and qosm_cfg_if.
//
// Usage:
//   in_ch  : timestamped events (arrival, departure, observe, drop mark).
//            One event is taken at a time; ready is low while it is processed.
//   out_ch : one result transaction per observe event (mean occupancy Q16.16,
//            idle fraction Q1.16, loss ratio Q1.16, loss-valid bit, observe count and sticky flags).
//   cfg_ch : register writes, always ready; write only while the block is idle.
// Between one input transaction and the next, every kind passes S_ELAP and S_UPD.
//   observe: the divider then works out the mean and the idle fraction, and in
//   finite mode also the loss ratio, each through S_LOAD, S_DIV and S_FIN, then
//   S_DONE. The division is done by the single restoring divider, one quotient bit
//   per cycle over a dividend of max(48, TIME_BITS) + 16 bits, used for every quotient.
// The result sits in an output register: if the receiver stalls, arrivals and
// departures keep flowing; the next observe waits after its division until the
// output register is free.
// Reset (synchronous, rst_n low) clears all statistics, the flags and the
// output valid, and sets finite_mode 0 and buffer_capacity 10.

module queue_occupancy_statistics_monitor_unit
  import qosm_pkg::*;
#(
  parameter int TIME_BITS = 48,
  parameter int OCC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  qosm_in_if.sink      in_ch,
  qosm_out_if.source   out_ch,
  qosm_cfg_if.sink     cfg_ch
);

  localparam int NUM_W   = (SUM_W > TIME_BITS) ? SUM_W : TIME_BITS;
  localparam int DVD_W   = NUM_W + FRAC_W;
  localparam int DEN_W   = (CNT_W > TIME_BITS) ? CNT_W : TIME_BITS;
  localparam int ITER_W  = $clog2(DVD_W + 1);
  localparam int CMP_W   = (OCC_BITS > CAP_W) ? OCC_BITS : CAP_W;

  // ---- registers ----
  state_t                 state_r, state_nxt;
  div_sel_t               sel_r, sel_nxt;
  logic                   finite_r;
  logic [CAP_W-1:0]       cap_r;

  logic [1:0]             req_r;
  logic [TIME_BITS-1:0]   now_r;
  logic                   drop_r;
  logic [TIME_BITS-1:0]   elap_r, elap_nxt;

  logic [OCC_BITS-1:0]    occ_r, occ_nxt;
  logic                   busy_r, busy_nxt;
  logic [TIME_BITS-1:0]   last_r, last_nxt;
  logic [TIME_BITS-1:0]   idle_r, idle_nxt;
  logic [SUM_W-1:0]       osum_r, osum_nxt;
  logic [CNT_W-1:0]       obs_r, obs_nxt;
  logic [CNT_W-1:0]       arr_r, arr_nxt;
  logic [CNT_W-1:0]       drp_r, drp_nxt;
  logic                   uf_r, uf_nxt;
  logic                   of_r, of_nxt;

  logic [DVD_W-1:0]       dq_r, dq_nxt;
  logic [DEN_W:0]         drem_r, drem_nxt;
  logic [DEN_W-1:0]       dden_r, dden_nxt;
  logic [ITER_W-1:0]      dcnt_r, dcnt_nxt;

  logic [MEAN_W-1:0]      mean_res_r, mean_res_nxt;
  logic [RATIO_W-1:0]     idle_res_r, idle_res_nxt;
  logic [RATIO_W-1:0]     loss_res_r, loss_res_nxt;

  logic                   ov_r, ov_nxt;
  logic [MEAN_W-1:0]      o_mean_r;
  logic [RATIO_W-1:0]     o_idle_r;
  logic [RATIO_W-1:0]     o_loss_r;
  logic                   o_lv_r;
  logic [CNT_W-1:0]       o_cnt_r;
  logic                   o_uf_r;
  logic                   o_of_r;
  logic                   o_load;

  // ---- datapath helpers ----
  logic                   in_take;
  logic [TIME_BITS:0]     idle_sum;
  logic [TIME_BITS-1:0]   idle_sat;
  logic [SUM_W:0]         osum_sum;
  logic [OCC_BITS-1:0]    occ_inc;
  logic [OCC_BITS-1:0]    occ_arr;
  logic                   arr_drop;
  logic [DEN_W:0]         rem_sh;
  logic [DEN_W+1:0]       rem_diff;
  logic                   rem_ge;
  logic [NUM_W-1:0]       ld_num;
  logic [DEN_W-1:0]       ld_den;
  logic                   den_zero;
  logic [MEAN_W-1:0]      q_mean;
  logic [RATIO_W-1:0]     q_ratio;

  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign idle_sum = {1'b0, idle_r} + {1'b0, elap_r};
  assign idle_sat = idle_sum[TIME_BITS] ? '1 : idle_sum[TIME_BITS-1:0];
  assign osum_sum = {1'b0, osum_r} + (SUM_W+1)'(occ_r);
  assign occ_inc  = (&occ_r) ? occ_r : occ_r + 1'b1;
  assign arr_drop = finite_r && drop_r;
  assign occ_arr  = arr_drop ? occ_r : occ_inc;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh   = {drem_r[DEN_W-1:0], dq_r[DVD_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, dden_r};
  assign rem_ge   = !rem_diff[DEN_W+1];

  always_comb begin
    case (sel_r)
      DIV_MEAN: begin
        ld_num = NUM_W'(osum_r);
        ld_den = DEN_W'(obs_r);
      end
      DIV_IDLE: begin
        ld_num = NUM_W'(idle_r);
        ld_den = DEN_W'(now_r);
      end
      DIV_LOSS: begin
        ld_num = NUM_W'(drp_r);
        ld_den = DEN_W'(arr_r);
      end
      default: begin
        ld_num = '0;
        ld_den = '0;
      end
    endcase
  end

  // saturate the finished quotient; zero divisor gives zero
  assign den_zero = (dden_r == '0);
  assign q_mean   = den_zero ? '0 :
                    (dq_r[DVD_W-1:MEAN_W] != '0) ? '1 : dq_r[MEAN_W-1:0];
  assign q_ratio  = den_zero ? '0 :
                    (dq_r > DVD_W'(ONE_Q16)) ? ONE_Q16 : dq_r[RATIO_W-1:0];

  assign o_load = (state_r == S_DONE) && (!ov_r || out_ch.ready);

  always_comb begin
    state_nxt    = state_r;
    sel_nxt      = sel_r;
    elap_nxt     = elap_r;
    occ_nxt      = occ_r;
    busy_nxt     = busy_r;
    last_nxt     = last_r;
    idle_nxt     = idle_r;
    osum_nxt     = osum_r;
    obs_nxt      = obs_r;
    arr_nxt      = arr_r;
    drp_nxt      = drp_r;
    uf_nxt       = uf_r;
    of_nxt       = of_r;
    dq_nxt       = dq_r;
    drem_nxt     = drem_r;
    dden_nxt     = dden_r;
    dcnt_nxt     = dcnt_r;
    mean_res_nxt = mean_res_r;
    idle_res_nxt = idle_res_r;
    loss_res_nxt = loss_res_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) state_nxt = S_ELAP;
      end

      S_ELAP: begin
        // time going backwards counts as no time
        elap_nxt  = (now_r >= last_r) ? now_r - last_r : '0;
        state_nxt = S_UPD;
      end

      S_UPD: begin
        state_nxt = S_IDLE;
        case (req_r)
          REQ_ARRIVAL: begin
            if (occ_r == '0) begin
              idle_nxt = idle_sat;
              busy_nxt = 1'b1;
              last_nxt = now_r;
            end
            if (arr_drop) begin
              if (!(&drp_r)) drp_nxt = drp_r + 1'b1;
            end
            occ_nxt = occ_arr;
            if (finite_r && (CMP_W'(occ_arr) > CMP_W'(cap_r))) of_nxt = 1'b1;
            if (!(&arr_r)) arr_nxt = arr_r + 1'b1;
          end
          REQ_DEPARTURE: begin
            if (occ_r == '0) begin
              uf_nxt = 1'b1;
            end else begin
              occ_nxt = occ_r - 1'b1;
              if (occ_r == OCC_BITS'(1)) begin
                busy_nxt = 1'b0;
                last_nxt = now_r;
              end
            end
          end
          REQ_OBSERVE: begin
            if (!(&obs_r)) obs_nxt = obs_r + 1'b1;
            osum_nxt  = osum_sum[SUM_W] ? '1 : osum_sum[SUM_W-1:0];
            if (!busy_r) idle_nxt = idle_sat;
            last_nxt  = now_r;
            sel_nxt   = DIV_MEAN;
            state_nxt = S_LOAD;
          end
          default: ;
        endcase
      end

      S_LOAD: begin
        dq_nxt    = {ld_num, {FRAC_W{1'b0}}};
        drem_nxt  = '0;
        dden_nxt  = ld_den;
        dcnt_nxt  = ITER_W'(DVD_W);
        state_nxt = S_DIV;
      end

      S_DIV: begin
        drem_nxt = rem_ge ? rem_diff[DEN_W:0] : rem_sh;
        dq_nxt   = {dq_r[DVD_W-2:0], rem_ge};
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == ITER_W'(1)) state_nxt = S_FIN;
      end

      S_FIN: begin
        case (sel_r)
          DIV_MEAN: begin
            mean_res_nxt = q_mean;
            sel_nxt      = DIV_IDLE;
            state_nxt    = S_LOAD;
          end
          DIV_IDLE: begin
            idle_res_nxt = q_ratio;
            if (finite_r) begin
              sel_nxt   = DIV_LOSS;
              state_nxt = S_LOAD;
            end else begin
              loss_res_nxt = '0;
              state_nxt    = S_DONE;
            end
          end
          default: begin
            loss_res_nxt = q_ratio;
            state_nxt    = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (o_load) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_ch.valid && out_ch.ready) ov_nxt = 1'b0;
    if (o_load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sel_r    <= DIV_MEAN;
      finite_r <= 1'b0;
      cap_r    <= CAP_RESET;
      occ_r    <= '0;
      busy_r   <= 1'b0;
      last_r   <= '0;
      idle_r   <= '0;
      osum_r   <= '0;
      obs_r    <= '0;
      arr_r    <= '0;
      drp_r    <= '0;
      uf_r     <= 1'b0;
      of_r     <= 1'b0;
      dcnt_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      occ_r   <= occ_nxt;
      busy_r  <= busy_nxt;
      last_r  <= last_nxt;
      idle_r  <= idle_nxt;
      osum_r  <= osum_nxt;
      obs_r   <= obs_nxt;
      arr_r   <= arr_nxt;
      drp_r   <= drp_nxt;
      uf_r    <= uf_nxt;
      of_r    <= of_nxt;
      dcnt_r  <= dcnt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_FINITE_MODE:     finite_r <= cfg_ch.data[0];
          REG_BUFFER_CAPACITY: cap_r    <= cfg_ch.data[CAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r  <= in_ch.req_type;
      now_r  <= in_ch.event_time;
      drop_r <= in_ch.was_dropped;
    end
    elap_r     <= elap_nxt;
    dq_r       <= dq_nxt;
    drem_r     <= drem_nxt;
    dden_r     <= dden_nxt;
    mean_res_r <= mean_res_nxt;
    idle_res_r <= idle_res_nxt;
    loss_res_r <= loss_res_nxt;
    if (o_load) begin
      o_mean_r <= mean_res_r;
      o_idle_r <= idle_res_r;
      o_loss_r <= loss_res_r;
      o_lv_r   <= finite_r;
      o_cnt_r  <= obs_r;
      o_uf_r   <= uf_r;
      o_of_r   <= of_r;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.mean_occupancy = o_mean_r;
  assign out_ch.idle_fraction  = o_idle_r;
  assign out_ch.loss_ratio     = o_loss_r;
  assign out_ch.loss_valid     = o_lv_r;
  assign out_ch.observe_count  = o_cnt_r;
  assign out_ch.underflow_seen = o_uf_r;
  assign out_ch.overflow_seen  = o_of_r;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for queue_occupancy_statistics_monitor_unit.
// Depends on qosm_pkg, the three channel interfaces and the RTL top level.
// A predictor mirrors the queue statistics and checks every observe result.

module testbench;
  import qosm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STALL_LIMIT   = 5000;
  localparam int          SETTLE_CYCLES = 300;
  localparam int          LONG_HOLD     = 600;
  localparam logic [1:0]  REQ_UNKNOWN   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd5;
  localparam logic [47:0] TMAX          = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] stamp;
    logic        dropped;
  } event_t;

  typedef struct packed {
    logic [MEAN_W-1:0]  mean_occupancy;
    logic [RATIO_W-1:0] idle_fraction;
    logic [RATIO_W-1:0] loss_ratio;
    logic               loss_valid;
    logic [CNT_W-1:0]   observe_count;
    logic               underflow_seen;
    logic               overflow_seen;
  } stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  qosm_in_if #(.TIME_BITS(48)) in_ch ();
  qosm_out_if                  out_ch ();
  qosm_cfg_if                  cfg_ch ();

  queue_occupancy_statistics_monitor_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  event_t event_backlog[$];
  stats_t expected_stats[$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_count    = 0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  logic        in_accepted;
  logic [47:0] stamp_cursor  = '0;

  int fail_count      = 0;
  int events_taken    = 0;
  int results_checked = 0;
  int writes_done     = 0;
  int quiet_cycles    = 0;

  // mirrored configuration and queue state
  logic        finite_on;
  logic [15:0] capacity;
  logic [15:0] q_depth        = '0;
  logic        q_busy         = 1'b0;
  logic [47:0] mark_time      = '0;
  logic [47:0] idle_ticks     = '0;
  logic [47:0] depth_sum      = '0;
  logic [31:0] obs_count      = '0;
  logic [31:0] arrivals       = '0;
  logic [31:0] drops          = '0;
  logic        underflow_flag = 1'b0;
  logic        overflow_flag  = 1'b0;

  function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic logic [47:0] since_mark(logic [47:0] now);
    return (now >= mark_time) ? now - mark_time : '0;
  endfunction

  // floor(num * 2^16 / den), clipped to ceiling; zero divisor gives zero
  function automatic logic [63:0] quotient_q16(logic [47:0] num, logic [47:0] den,
                                               logic [63:0] ceiling);
    logic [63:0] q;
    if (den == '0) return '0;
    q = {num, 16'h0000} / {16'h0000, den};
    return (q > ceiling) ? ceiling : q;
  endfunction

  function automatic bit track_event(logic [1:0] kind, logic [47:0] now, logic dropped,
                                     output stats_t res);
    logic [63:0] mean_q, idle_q, loss_q;
    res = '0;
    case (kind)
      REQ_ARRIVAL: begin
        if (q_depth == '0) begin
          idle_ticks = add_sat48(idle_ticks, since_mark(now));
          q_busy     = 1'b1;
          mark_time  = now;
        end
        if (finite_on && dropped) begin
          if (drops != '1) drops++;
        end else if (q_depth != '1) begin
          q_depth++;
        end
        if (finite_on && q_depth > capacity) overflow_flag = 1'b1;
        if (arrivals != '1) arrivals++;
        return 1'b0;
      end
      REQ_DEPARTURE: begin
        if (q_depth == '0) begin
          underflow_flag = 1'b1;
          return 1'b0;
        end
        q_depth--;
        if (q_depth == '0) begin
          q_busy    = 1'b0;
          mark_time = now;
        end
        return 1'b0;
      end
      REQ_OBSERVE: begin
        if (obs_count != '1) obs_count++;
        depth_sum = add_sat48(depth_sum, {32'h0, q_depth});
        if (!q_busy) idle_ticks = add_sat48(idle_ticks, since_mark(now));
        mark_time = now;
        mean_q = quotient_q16(depth_sum, {16'h0, obs_count}, 64'hFFFF_FFFF);
        idle_q = quotient_q16(idle_ticks, now, 64'h1_0000);
        loss_q = finite_on ? quotient_q16({16'h0, drops}, {16'h0, arrivals}, 64'h1_0000) : '0;
        res.mean_occupancy = mean_q[MEAN_W-1:0];
        res.idle_fraction  = idle_q[RATIO_W-1:0];
        res.loss_ratio     = loss_q[RATIO_W-1:0];
        res.loss_valid     = finite_on;
        res.observe_count  = obs_count;
        res.underflow_seen = underflow_flag;
        res.overflow_seen  = overflow_flag;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // sampling, prediction, checking and watchdog
  always @(posedge clk) begin : monitor
    stats_t predicted;
    stats_t seen;
    if (!rst_n) begin
      in_accepted <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_accepted <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        events_taken++;
        if (track_event(in_ch.req_type, in_ch.event_time, in_ch.was_dropped, predicted))
          expected_stats = {expected_stats, predicted};
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.mean_occupancy = out_ch.mean_occupancy;
        seen.idle_fraction  = out_ch.idle_fraction;
        seen.loss_ratio     = out_ch.loss_ratio;
        seen.loss_valid     = out_ch.loss_valid;
        seen.observe_count  = out_ch.observe_count;
        seen.underflow_seen = out_ch.underflow_seen;
        seen.overflow_seen  = out_ch.overflow_seen;
        if (expected_stats.size() == 0) begin
          $error("result transaction with no observe event outstanding");
          fail_count++;
        end else begin
          predicted = expected_stats.pop_front();
          check_field("mean_occupancy", 64'(predicted.mean_occupancy),
                      64'(seen.mean_occupancy));
          check_field("idle_fraction", 64'(predicted.idle_fraction),
                      64'(seen.idle_fraction));
          check_field("loss_ratio", 64'(predicted.loss_ratio), 64'(seen.loss_ratio));
          check_field("loss_valid", 64'(predicted.loss_valid), 64'(seen.loss_valid));
          check_field("observe_count", 64'(predicted.observe_count),
                      64'(seen.observe_count));
          check_field("underflow_seen", 64'(predicted.underflow_seen),
                      64'(seen.underflow_seen));
          check_field("overflow_seen", 64'(predicted.overflow_seen),
                      64'(seen.overflow_seen));
          results_checked++;
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // event driver: holds an offer until taken, idles at random between offers
  always @(negedge clk) begin : driver
    event_t pick;
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.req_type    <= REQ_ARRIVAL;
      in_ch.event_time  <= '0;
      in_ch.was_dropped <= 1'b0;
    end else if (!in_ch.valid || in_accepted) begin
      if (event_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pick = event_backlog.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= pick.kind;
        in_ch.event_time  <= pick.stamp;
        in_ch.was_dropped <= pick.dropped;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin : receiver
    if (hold_requests != hold_served) begin
      hold_served  <= hold_requests;
      hold_count   <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_count > 0) begin
      out_ch.ready <= 1'b0;
      hold_count   <= hold_count - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_event(logic [1:0] kind, logic [47:0] stamp, logic dropped);
    event_t e;
    e.kind    = kind;
    e.stamp   = stamp;
    e.dropped = dropped;
    event_backlog = {event_backlog, e};
  endtask

  // mostly a well-behaved timeline; now and then a jump anywhere, backwards included
  task automatic queue_random_events(int count);
    int r;
    logic [1:0] kind;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 40)      kind = REQ_ARRIVAL;
      else if (r < 74) kind = REQ_DEPARTURE;
      else if (r < 96) kind = REQ_OBSERVE;
      else             kind = REQ_UNKNOWN;
      if ($urandom_range(99) < 5)
        stamp_cursor = 48'({$urandom, $urandom});
      else
        stamp_cursor = stamp_cursor + 48'($urandom_range(1000));
      queue_event(kind, stamp_cursor, $urandom_range(99) < 30);
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_FINITE_MODE:     finite_on = val[0];
      REG_BUFFER_CAPACITY: capacity  = val[CAP_W-1:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for every transaction to finish, then let any arrival or departure settle
  task automatic drain();
    while (event_backlog.size() != 0 || in_ch.valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_FINITE_MODE;
    cfg_ch.data       = '0;

    finite_on      = 1'b0;
    capacity       = CAP_RESET;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset configuration: zero divisor, empty departure, ignored drop mark,
    // unknown kind, timestamps at both ends, backwards time and idle-time saturation
    queue_event(REQ_OBSERVE, 48'd0, 1'b0);
    queue_event(REQ_DEPARTURE, 48'd5, 1'b0);
    queue_event(REQ_ARRIVAL, 48'd10, 1'b1);
    queue_event(REQ_ARRIVAL, 48'd20, 1'b0);
    queue_event(REQ_OBSERVE, 48'd30, 1'b0);
    queue_event(REQ_UNKNOWN, 48'd35, 1'b1);
    queue_event(REQ_DEPARTURE, 48'd40, 1'b0);
    queue_event(REQ_DEPARTURE, 48'd50, 1'b0);
    queue_event(REQ_OBSERVE, 48'd60, 1'b0);
    queue_event(REQ_OBSERVE, TMAX, 1'b0);
    queue_event(REQ_OBSERVE, 48'd0, 1'b0);
    queue_event(REQ_OBSERVE, TMAX, 1'b0);
    queue_event(REQ_ARRIVAL, TMAX, 1'b0);
    queue_event(REQ_OBSERVE, 48'd100, 1'b0);
    queue_event(REQ_DEPARTURE, 48'd100, 1'b0);
    drain();

    // finite mode, capacity of one; upper data bits must be ignored
    write_register(REG_FINITE_MODE, 32'hFFFF_FFFF);
    write_register(REG_BUFFER_CAPACITY, 32'hABCD_0001);
    queue_event(REQ_ARRIVAL, 48'd200, 1'b1);
    queue_event(REQ_OBSERVE, 48'd210, 1'b0);
    queue_event(REQ_ARRIVAL, 48'd220, 1'b0);
    queue_event(REQ_ARRIVAL, 48'd230, 1'b0);
    queue_event(REQ_OBSERVE, 48'd240, 1'b0);
    queue_event(REQ_DEPARTURE, 48'd250, 1'b0);
    queue_event(REQ_DEPARTURE, 48'd260, 1'b0);
    queue_event(REQ_OBSERVE, 48'd270, 1'b0);
    queue_event(REQ_ARRIVAL, 48'd280, 1'b1);
    queue_event(REQ_OBSERVE, 48'd290, 1'b0);
    drain();

    stamp_cursor = 48'd300;
    send_idle_pct = 37;
    recv_idle_pct = 46;
    write_register(REG_FINITE_MODE, 32'd1);
    write_register(REG_BUFFER_CAPACITY, $urandom_range(8));
    queue_random_events(250);
    drain();

    send_idle_pct = 46;
    recv_idle_pct = 37;
    write_register(REG_FINITE_MODE, 32'hFFFF_FFFE);
    write_register(REG_BUFFER_CAPACITY, 32'h0000_FFFF);
    write_register(REG_UNUSED, $urandom);
    queue_random_events(250);
    drain();

    // no idling; a long output hold-off backs the block up, then a full drain
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(REG_FINITE_MODE, 32'd1);
    queue_random_events(120);
    @(posedge clk);
    hold_requests++;
    drain();
    queue_random_events(130);
    drain();

    $display("Run covered %0d events, %0d statistics results and %0d register writes,",
             events_taken, results_checked, writes_done);
    $display("in both modes, with random stalls on each side and one long output hold-off.");
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
